// ===== hw/rtl/pbc_pkg.sv =====
// Shared types and default sizes for the polygon box-center and perimeter block.
package pbc_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int PERIM_WIDTH_DEF = 40;
    // root width for a coordinate difference of COORD_WIDTH_DEF + 1 bits
    localparam int ROOT_WIDTH_DEF  = COORD_WIDTH_DEF + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_FEED,
        ST_FEED_CLOSE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

// ===== hw/rtl/pbc_sqrt_cell.sv =====
// One cell of the square root chain: settles one root bit per item and passes it on.
module pbc_sqrt_cell #(
    parameter int ROOT_W = pbc_pkg::ROOT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [ROOT_W+1:0]     i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic                  o_valid,
    output logic [ROOT_W+1:0]     o_rem,
    output logic [ROOT_W-1:0]     o_root,
    output logic [2*ROOT_W-1:0]   o_rad
);

    logic [ROOT_W+1:0]   w_rem_sh;
    logic [ROOT_W+1:0]   w_trial;
    logic                w_fits;
    logic [ROOT_W+1:0]   n_rem;
    logic [ROOT_W-1:0]   n_root;
    logic [2*ROOT_W-1:0] n_rad;
    logic                r_valid;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [2*ROOT_W-1:0] r_rad;

    // bring down the next two radicand bits and try a one in this root place
    always_comb begin
        w_rem_sh = {i_rem[ROOT_W-1:0], i_rad[2*ROOT_W-1 -: 2]};
        w_trial  = {i_root, 2'b01};
        w_fits   = (w_rem_sh >= w_trial);
        n_rem    = w_fits ? (w_rem_sh - w_trial) : w_rem_sh;
        n_root   = {i_root[ROOT_W-2:0], w_fits};
        n_rad    = {i_rad[2*ROOT_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rad  <= n_rad;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_rad   = r_rad;

endmodule

// ===== hw/rtl/pbc_sqrt_chain.sv =====
// Row of ROOT_W square root cells giving the floor root of a radicand.
module pbc_sqrt_chain #(
    parameter int ROOT_W = pbc_pkg::ROOT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root
);

    logic                w_valid [0:ROOT_W];
    logic [ROOT_W+1:0]   w_rem   [0:ROOT_W];
    logic [ROOT_W-1:0]   w_root  [0:ROOT_W];
    logic [2*ROOT_W-1:0] w_rad   [0:ROOT_W];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;
    assign w_rad[0]   = i_rad;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        pbc_sqrt_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .i_rad   (w_rad[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1]),
            .o_rad   (w_rad[g+1])
        );
    end

    assign o_valid = w_valid[ROOT_W];
    assign o_root  = w_root[ROOT_W];

endmodule

// ===== hw/rtl/polygon_bbox_center_perimeter.sv =====
// Polygon bounding-box center and perimeter: FSM, vertex registers, square and sum stages.
// Vertices arrive one per item and are handled one at a time. The first vertex of a
// polygon is only registered, and is placed in the output register when it is also
// the last. Every later vertex passes the difference, square and sum stages and then
// the square root chain, one cell per root bit (COORD_WIDTH + 1 cells), and input is
// held off until its edge lengths have left the chain. For the last vertex of a polygon
// with at least two vertices, the closing edge follows the last edge into the chain in
// the next cycle, and the result is then placed in the output register. A finished
// result waits in the output register while the next polygon's vertices are accepted;
// if the next result is ready before that one is taken, input is held off until it is.
module polygon_bbox_center_perimeter #(
    parameter int COORD_WIDTH = pbc_pkg::COORD_WIDTH_DEF,
    parameter int PERIM_WIDTH = pbc_pkg::PERIM_WIDTH_DEF,
    localparam int IN_DW  = ((2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((2 * COORD_WIDTH + PERIM_WIDTH + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // x_coord, y_coord
    input  logic              s_axis_tlast,   // last
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // center_x, center_y, perimeter
    output logic              m_axis_tuser    // overflow
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = PERIM_WIDTH;
    localparam int RW = CW + 1;
    localparam int SW = ((PW > RW) ? PW : RW) + 1;

    pbc_pkg::t_state r_state;
    pbc_pkg::t_state n_state;

    logic signed [CW-1:0] w_in_x;
    logic signed [CW-1:0] w_in_y;
    logic                 w_accept;
    logic                 w_ld_first;
    logic                 w_ld_next;
    logic                 w_feed;
    logic                 w_emit;

    logic signed [CW-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [CW-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic                 r_open;
    logic                 r_last;

    logic signed [CW:0]   r_dx, r_dy, r_cdx, r_cdy;
    logic [CW:0]          w_mdx, w_mdy, w_mcdx, w_mcdy;
    logic [2*CW+1:0]      r_sq_dx, r_sq_dy, r_sq_cdx, r_sq_cdy;
    logic [2*RW-1:0]      r_rad_edge, r_rad_close;

    logic [2*RW-1:0]      w_chain_rad;
    logic                 w_root_valid;
    logic [RW-1:0]        w_root;
    logic [1:0]           r_pend;

    logic [PW-1:0]        r_sum;
    logic                 r_sat;
    logic [SW-1:0]        w_sum_ext;
    logic                 w_sum_over;

    logic signed [CW:0]   w_mid_x, w_mid_y;
    logic                 r_out_valid;
    logic [CW-1:0]        r_out_cx, r_out_cy;
    logic [PW-1:0]        r_out_perim;
    logic                 r_out_ovf;

    assign w_in_x = s_axis_tdata[CW-1:0];
    assign w_in_y = s_axis_tdata[2*CW-1:CW];

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_accept      = 1'b0;
        w_ld_first    = 1'b0;
        w_ld_next     = 1'b0;
        w_feed        = 1'b0;
        w_chain_rad   = r_rad_edge;
        w_emit        = 1'b0;
        case (r_state)
            pbc_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_accept      = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    if (!r_open) begin
                        w_ld_first = 1'b1;
                        n_state    = s_axis_tlast ? pbc_pkg::ST_EMIT : pbc_pkg::ST_IDLE;
                    end else begin
                        w_ld_next = 1'b1;
                        n_state   = pbc_pkg::ST_SQUARE;
                    end
                end
            end
            pbc_pkg::ST_SQUARE: begin
                n_state = pbc_pkg::ST_SUM;
            end
            pbc_pkg::ST_SUM: begin
                n_state = pbc_pkg::ST_FEED;
            end
            pbc_pkg::ST_FEED: begin
                w_feed  = 1'b1;
                n_state = r_last ? pbc_pkg::ST_FEED_CLOSE : pbc_pkg::ST_DRAIN;
            end
            pbc_pkg::ST_FEED_CLOSE: begin
                w_feed      = 1'b1;
                w_chain_rad = r_rad_close;
                n_state     = pbc_pkg::ST_DRAIN;
            end
            pbc_pkg::ST_DRAIN: begin
                if (r_pend == 2'd0) begin
                    n_state = r_last ? pbc_pkg::ST_EMIT : pbc_pkg::ST_IDLE;
                end
            end
            pbc_pkg::ST_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    w_emit  = 1'b1;
                    n_state = pbc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_last <= 1'b0;
            r_pend <= 2'd0;
        end else begin
            if (w_accept) begin
                r_open <= !s_axis_tlast;
                r_last <= s_axis_tlast;
            end
            r_pend <= r_pend + {1'b0, w_feed} - {1'b0, w_root_valid};
        end
    end

    // ------------------------------------------------------- vertex and box
    always_ff @(posedge i_clk) begin
        if (w_ld_first) begin
            r_first_x <= w_in_x;
            r_first_y <= w_in_y;
            r_min_x   <= w_in_x;
            r_max_x   <= w_in_x;
            r_min_y   <= w_in_y;
            r_max_y   <= w_in_y;
        end else if (w_ld_next) begin
            if (w_in_x < r_min_x) r_min_x <= w_in_x;
            if (w_in_x > r_max_x) r_max_x <= w_in_x;
            if (w_in_y < r_min_y) r_min_y <= w_in_y;
            if (w_in_y > r_max_y) r_max_y <= w_in_y;
        end
        if (w_accept) begin
            r_prev_x <= w_in_x;
            r_prev_y <= w_in_y;
        end
        if (w_ld_next) begin
            r_dx  <= {w_in_x[CW-1], w_in_x} - {r_prev_x[CW-1], r_prev_x};
            r_dy  <= {w_in_y[CW-1], w_in_y} - {r_prev_y[CW-1], r_prev_y};
            r_cdx <= {r_first_x[CW-1], r_first_x} - {w_in_x[CW-1], w_in_x};
            r_cdy <= {r_first_y[CW-1], r_first_y} - {w_in_y[CW-1], w_in_y};
        end
    end

    // ------------------------------------------------- squares and radicands
    assign w_mdx  = r_dx[CW]  ? (~r_dx + 1'b1)  : r_dx;
    assign w_mdy  = r_dy[CW]  ? (~r_dy + 1'b1)  : r_dy;
    assign w_mcdx = r_cdx[CW] ? (~r_cdx + 1'b1) : r_cdx;
    assign w_mcdy = r_cdy[CW] ? (~r_cdy + 1'b1) : r_cdy;

    always_ff @(posedge i_clk) begin
        if (r_state == pbc_pkg::ST_SQUARE) begin
            r_sq_dx  <= (2*CW+2)'(w_mdx)  * (2*CW+2)'(w_mdx);
            r_sq_dy  <= (2*CW+2)'(w_mdy)  * (2*CW+2)'(w_mdy);
            r_sq_cdx <= (2*CW+2)'(w_mcdx) * (2*CW+2)'(w_mcdx);
            r_sq_cdy <= (2*CW+2)'(w_mcdy) * (2*CW+2)'(w_mcdy);
        end
        if (r_state == pbc_pkg::ST_SUM) begin
            r_rad_edge  <= r_sq_dx + r_sq_dy;
            r_rad_close <= r_sq_cdx + r_sq_cdy;
        end
    end

    pbc_sqrt_chain #(
        .ROOT_W (RW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_feed),
        .i_rad   (w_chain_rad),
        .o_valid (w_root_valid),
        .o_root  (w_root)
    );

    // ------------------------------------------------- saturating perimeter
    assign w_sum_ext  = SW'(r_sum) + SW'(w_root);
    assign w_sum_over = |w_sum_ext[SW-1:PW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sat <= 1'b0;
        end else if (w_ld_first) begin
            r_sum <= '0;
            r_sat <= 1'b0;
        end else if (w_root_valid) begin
            if (w_sum_over) begin
                r_sum <= '1;
                r_sat <= 1'b1;
            end else begin
                r_sum <= w_sum_ext[PW-1:0];
            end
        end
    end

    // -------------------------------------------------------------- output
    assign w_mid_x = {r_min_x[CW-1], r_min_x} + {r_max_x[CW-1], r_max_x};
    assign w_mid_y = {r_min_y[CW-1], r_min_y} + {r_max_y[CW-1], r_max_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_cx    <= w_mid_x[CW:1];
            r_out_cy    <= w_mid_y[CW:1];
            r_out_perim <= r_sum;
            r_out_ovf   <= r_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'({r_out_perim, r_out_cy, r_out_cx});
    assign m_axis_tuser  = r_out_ovf;

    // ----------------------------------------------------------- assertions
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("more edges in the root chain than one vertex launches");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pbc_pkg::ST_IDLE) |-> (r_pend == 2'd0 && !w_root_valid))
        else $error("ready for a vertex while edge lengths are still pending");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == pbc_pkg::ST_EMIT))
        else $error("result raised outside the emit step");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (&r_out_perim))
        else $error("overflow flagged on a perimeter that is not saturated");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the polygon box-center and perimeter block.
`timescale 1ns / 100ps

module testbench;

    localparam int CW    = pbc_pkg::COORD_WIDTH_DEF;
    localparam int PW    = pbc_pkg::PERIM_WIDTH_DEF;
    localparam int IN_W  = ((2 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + PW + 7) / 8) * 8;

    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};
    localparam logic [CW-1:0] COORD_MAX = ~COORD_MIN;
    localparam logic [PW-1:0] PERIM_MAX = '1;

    // watchdog limit, set well above the slowest item and the long receiver hold-off
    localparam int QUIET_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2 * (CW + 8);

    typedef struct {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [PW-1:0]        perim;
        logic                 ovf;
    } t_shape;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;   // x_coord, y_coord
    logic              s_axis_tlast = 1'b0; // last
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // center_x, center_y, perimeter
    logic              m_axis_tuser;        // overflow

    polygon_bbox_center_perimeter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    t_shape pending_shapes[$];
    int     mismatch_count = 0;
    bit     gaps_on = 1'b0;
    int     hold_len = 0;
    int     hold_seq = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;

    // shadow state of the block
    logic signed [CW-1:0] vx0, vy0, vx_prev, vy_prev;
    logic signed [CW-1:0] bx_lo, bx_hi, by_lo, by_hi;
    logic [PW-1:0]        perim_acc;
    bit                   perim_sat;
    bit                   shape_open;

    function automatic logic [63:0] edge_len_floor(input logic signed [CW:0] dx,
                                                   input logic signed [CW:0] dy);
        logic signed [CW:0] mx, my;
        logic [63:0] ax, ay, norm, r, t;
        mx = dx[CW] ? -dx : dx;
        my = dy[CW] ? -dy : dy;
        ax = {{(63 - CW){1'b0}}, mx};
        ay = {{(63 - CW){1'b0}}, my};
        norm = ax * ax + ay * ay;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= norm)
                r = t;
        end
        return r;
    endfunction

    function automatic logic signed [CW:0] coord_diff(input logic signed [CW-1:0] a,
                                                      input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        d = {a[CW-1], a} - {b[CW-1], b};
        return d;
    endfunction

    function automatic logic signed [CW-1:0] mid_floor(input logic signed [CW-1:0] lo,
                                                       input logic signed [CW-1:0] hi);
        logic [CW:0] s;
        s = {lo[CW-1], lo} + {hi[CW-1], hi};
        return s[CW:1];
    endfunction

    task automatic add_edge(input logic [63:0] len);
        logic [PW:0] s;
        s = {1'b0, perim_acc} + len[PW:0];
        if (len > {{(64 - PW){1'b0}}, PERIM_MAX} || s > {1'b0, PERIM_MAX}) begin
            perim_acc = PERIM_MAX;
            perim_sat = 1'b1;
        end else begin
            perim_acc = s[PW-1:0];
        end
    endtask

    task automatic fold_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input bit last, output bit done, output t_shape res);
        if (!shape_open) begin
            vx0 = x;
            vy0 = y;
            bx_lo = x;
            bx_hi = x;
            by_lo = y;
            by_hi = y;
            perim_acc = '0;
            perim_sat = 1'b0;
        end else begin
            if (x < bx_lo) bx_lo = x;
            if (x > bx_hi) bx_hi = x;
            if (y < by_lo) by_lo = y;
            if (y > by_hi) by_hi = y;
            add_edge(edge_len_floor(coord_diff(x, vx_prev), coord_diff(y, vy_prev)));
            // close the loop back to the first vertex
            if (last)
                add_edge(edge_len_floor(coord_diff(vx0, x), coord_diff(vy0, y)));
        end
        vx_prev = x;
        vy_prev = y;
        shape_open = !last;
        done = last;
        res.cx = mid_floor(bx_lo, bx_hi);
        res.cy = mid_floor(by_lo, by_hi);
        res.perim = perim_acc;
        res.ovf = perim_sat;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_shape();
        t_shape want;
        logic signed [CW-1:0] got_cx, got_cy;
        logic [PW-1:0] got_perim;
        if (pending_shapes.size() == 0) begin
            report_mismatch("result item with nothing expected");
        end else begin
            want = pending_shapes.pop_front();
            got_cx = m_axis_tdata[CW-1:0];
            got_cy = m_axis_tdata[2*CW-1:CW];
            got_perim = m_axis_tdata[2*CW+PW-1:2*CW];
            if (got_cx !== want.cx)
                report_mismatch($sformatf("center_x got %0d want %0d", got_cx, want.cx));
            if (got_cy !== want.cy)
                report_mismatch($sformatf("center_y got %0d want %0d", got_cy, want.cy));
            if (got_perim !== want.perim)
                report_mismatch($sformatf("perimeter got %0d want %0d",
                                          got_perim, want.perim));
            if (m_axis_tuser !== want.ovf)
                report_mismatch($sformatf("overflow got %b want %b",
                                          m_axis_tuser, want.ovf));
        end
    endtask

    // receiver: check each result item, drive tready
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            check_shape();
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (gaps_on) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 9);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_vertex(input logic [CW-1:0] x, input logic [CW-1:0] y,
                               input bit last);
        bit done;
        t_shape res;
        if (gaps_on && $urandom_range(0, 99) < 9) begin
            // idle with junk on the bus
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= IN_W'({$urandom(), $urandom()});
            s_axis_tlast <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {y, x};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        fold_vertex(x, y, last, done, res);
        if (done)
            pending_shapes.insert(pending_shapes.size(), res);
    endtask

    // drop valid and hold until every expected result has come out
    task automatic sender_rest();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_shapes.size() != 0);
    endtask

    function automatic logic [CW-1:0] pick_coord(input logic [CW-1:0] anchor);
        logic [CW-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = COORD_MIN;
            1:       v = COORD_MAX;
            2, 3:    v = anchor + CW'($urandom_range(0, 2047)) - CW'(1024);
            default: v = CW'($urandom());
        endcase
        return v;
    endfunction

    task automatic test_single_vertex();
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, 1'b1);
        send_vertex('0, '0, 1'b1);
    endtask

    task automatic test_two_vertices();
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        send_vertex(CW'(256), CW'(-512), 1'b0);
        send_vertex(CW'(256), CW'(-512), 1'b1);
    endtask

    task automatic test_box_order();
        // first vertex inside the box, extremes arrive out of order
        send_vertex(CW'(1000), CW'(-3), 1'b0);
        send_vertex(CW'(-7000), CW'(50000), 1'b0);
        send_vertex(CW'(90000), CW'(-123456), 1'b0);
        send_vertex(CW'(5), CW'(7), 1'b0);
        send_vertex(CW'(-1), CW'(1), 1'b1);
    endtask

    task automatic test_corners();
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MIN, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b1);
        send_vertex(COORD_MAX, '0, 1'b0);
        send_vertex('0, COORD_MIN, 1'b0);
        send_vertex(CW'(-1), CW'(-1), 1'b1);
    endtask

    task automatic test_backpressure();
        hold_len = 1500;
        hold_seq++;
        for (int k = 0; k < 24; k++)
            send_vertex(CW'($urandom()), CW'($urandom()), (k % 3) == 2);
        sender_rest();
    endtask

    task automatic test_long_edges();
        // opposite corners back and forth: the longest edges there are
        for (int k = 0; k < 8; k++) begin
            if (k % 2 == 0)
                send_vertex(COORD_MIN, COORD_MIN, 1'b0);
            else
                send_vertex(COORD_MAX, COORD_MAX, k == 7);
        end
        // a short polygon right after starts from a clean sum
        send_vertex(CW'(3), CW'(4), 1'b0);
        send_vertex('0, '0, 1'b1);
    endtask

    task automatic test_random();
        int sent;
        int len;
        logic [CW-1:0] ax, ay;
        sent = 0;
        while (sent < 900) begin
            gaps_on = (sent < 250 || sent >= 450);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            ax = CW'($urandom());
            ay = CW'($urandom());
            for (int k = 0; k < len; k++)
                send_vertex(pick_coord(ax), pick_coord(ay), k == len - 1);
            sent += len;
            if ($urandom_range(0, 19) == 0)
                sender_rest();
        end
    endtask

    initial begin
        shape_open = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gaps_on = 1'b1;
        test_single_vertex();
        test_two_vertices();
        test_box_order();
        test_corners();
        gaps_on = 1'b0;
        test_backpressure();
        test_long_edges();
        test_random();
        sender_rest();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
